/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the IRC line field splitter.
// Needs clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/irc_lfs_pkg.sv */
// Shared types, codes and constants of the IRC line field splitter.
// No dependencies; imported by every module of the block.
package irc_lfs_pkg;

  // Parameter count saturates here; index shown on the port clamps at 15.
  localparam int MAX_PARAM_INDEX = 15;
  localparam int PARAM_W         = $clog2(MAX_PARAM_INDEX + 1);
  localparam int PNUM_SHOWN_MAX  = 15;

  // Results one byte can cause, and the result queue.
  localparam int MAX_RESULTS = 3;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  // Field kinds.
  localparam logic [3:0] K_KEY     = 4'd0;
  localparam logic [3:0] K_VALUE   = 4'd1;
  localparam logic [3:0] K_NICK    = 4'd2;
  localparam logic [3:0] K_USER    = 4'd3;
  localparam logic [3:0] K_HOST    = 4'd4;
  localparam logic [3:0] K_COMMAND = 4'd5;
  localparam logic [3:0] K_MIDDLE  = 4'd6;
  localparam logic [3:0] K_TRAIL   = 4'd7;
  localparam logic [3:0] K_CTCP    = 4'd8;
  localparam logic [3:0] K_STATUS  = 4'd9;

  // Line status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EMPTY_FIRST = 2'd1;
  localparam logic [1:0] ST_NO_CMD      = 2'd2;
  localparam logic [1:0] ST_BAD_CTCP    = 2'd3;

  // Parse regions.
  localparam logic [3:0] R_FIRST       = 4'd0;
  localparam logic [3:0] R_KEY         = 4'd1;
  localparam logic [3:0] R_VALUE       = 4'd2;
  localparam logic [3:0] R_AFTER_TAGS  = 4'd3;
  localparam logic [3:0] R_NICK        = 4'd4;
  localparam logic [3:0] R_USER        = 4'd5;
  localparam logic [3:0] R_HOST        = 4'd6;
  localparam logic [3:0] R_CMD_FIRST   = 4'd7;
  localparam logic [3:0] R_CMD         = 4'd8;
  localparam logic [3:0] R_PARAM       = 4'd9;
  localparam logic [3:0] R_MIDDLE      = 4'd10;
  localparam logic [3:0] R_TRAIL_FIRST = 4'd11;
  localparam logic [3:0] R_TRAIL       = 4'd12;
  localparam logic [3:0] R_CTCP_CMD    = 4'd13;
  localparam logic [3:0] R_CTCP_REST   = 4'd14;
  localparam logic [3:0] R_ERR         = 4'd15;

  // Command matcher codes: start, full PRIVMSG, full NOTICE, no match.
  localparam logic [3:0] M_START   = 4'd0;
  localparam logic [3:0] M_PRIVMSG = 4'd7;
  localparam logic [3:0] M_NOTICE  = 4'd13;
  localparam logic [3:0] M_DEAD    = 4'd15;

  // Octets with meaning to the parser.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CTCP  = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] field_kind;
    logic [7:0] out_byte;
    logic [3:0] param_number;
    logic       field_start;
    logic       line_done;
    logic [1:0] line_status;
  } out_beat_t;

  // Results of one parsed byte, compacted from slot 0 upward.
  typedef struct packed {
    logic [1:0]                       cnt;
    out_beat_t [MAX_RESULTS-1:0]      beats;
  } res_push_t;

endpackage

/* rtl/irc_lfs_parse.sv */
// Per-byte parser of the IRC line field splitter: parse state and result build.
// Depends on irc_lfs_pkg.
module irc_lfs_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  irc_lfs_pkg::in_beat_t beat,
  output irc_lfs_pkg::res_push_t push
);
  import irc_lfs_pkg::*;

  logic [3:0]         region_r, region_nxt;
  logic               esc_r, esc_nxt;
  logic [3:0]         cmatch_r, cmatch_nxt;
  logic [PARAM_W-1:0] param_r, param_nxt;
  logic [7:0]         held_byte_r, held_byte_nxt;
  logic [3:0]         held_kind_r, held_kind_nxt;
  logic               held_vld_r, held_vld_nxt;
  logic               held_start_r, held_start_nxt;
  logic               ctcp_r, ctcp_nxt;
  logic               cmd_seen_r, cmd_seen_nxt;
  logic               start_r, start_nxt;
  logic [1:0]         lerr_r, lerr_nxt;

  logic [7:0] b;
  logic       eol;
  logic       closing;
  logic       do_cmd;
  logic [3:0] pnum;
  out_beat_t  prim, eol_rel, stat;
  logic       prim_vld, eol_rel_vld;
  logic [1:0] n;

  function automatic out_beat_t mk_beat(input logic [3:0] kind, input logic [7:0] data,
                                        input logic start, input logic [3:0] pn);
    out_beat_t r;
    r.field_kind   = kind;
    r.out_byte     = data;
    r.param_number = (kind == K_MIDDLE || kind == K_TRAIL || kind == K_CTCP) ? pn : 4'd0;
    r.field_start  = start;
    r.line_done    = 1'b0;
    r.line_status  = ST_OK;
    return r;
  endfunction

  // Next letter expected by the command matcher.
  function automatic logic [7:0] cmd_letter(input logic [3:0] m);
    logic [7:0] c;
    case (m)
      4'd1:    c = "R";
      4'd2:    c = "I";
      4'd3:    c = "V";
      4'd4:    c = "M";
      4'd5:    c = "S";
      4'd6:    c = "G";
      4'd8:    c = "O";
      4'd9:    c = "T";
      4'd10:   c = "I";
      4'd11:   c = "C";
      4'd12:   c = "E";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] cmd_next(input logic [3:0] m, input logic [7:0] c);
    logic [3:0] r;
    if (m == M_START) begin
      r = (c == "P") ? 4'd1 : (c == "N") ? 4'd8 : M_DEAD;
    end else if ((m >= 4'd1 && m <= 4'd6) || (m >= 4'd8 && m <= 4'd12)) begin
      r = (c == cmd_letter(m)) ? m + 4'd1 : M_DEAD;
    end else begin
      r = M_DEAD;
    end
    return r;
  endfunction

  function automatic logic [7:0] unesc(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ":":     r = CH_SEMI;
      "s":     r = CH_SPACE;
      "r":     r = 8'h0D;
      "n":     r = 8'h0A;
      default: r = c;
    endcase
    return r;
  endfunction

  assign b    = beat.data_byte;
  assign eol  = beat.line_end;
  assign pnum = (int'(param_r) > PNUM_SHOWN_MAX) ? 4'(PNUM_SHOWN_MAX) : 4'(param_r);

  always_comb begin
    region_nxt     = region_r;
    esc_nxt        = esc_r;
    cmatch_nxt     = cmatch_r;
    param_nxt      = param_r;
    held_byte_nxt  = held_byte_r;
    held_kind_nxt  = held_kind_r;
    held_vld_nxt   = held_vld_r;
    held_start_nxt = held_start_r;
    ctcp_nxt       = ctcp_r;
    cmd_seen_nxt   = cmd_seen_r;
    start_nxt      = start_r;
    lerr_nxt       = lerr_r;
    do_cmd         = 1'b0;
    prim           = mk_beat(held_kind_r, held_byte_r, held_start_r, pnum);
    prim_vld       = 1'b0;
    eol_rel        = '0;
    eol_rel_vld    = 1'b0;
    stat           = '0;

    closing = eol && (region_r == R_CTCP_CMD || region_r == R_CTCP_REST) && b == CH_CTCP;

    if (closing) begin
      // release the held byte, drop the closing framing octet
      prim_vld     = held_vld_r;
      held_vld_nxt = 1'b0;
    end else begin
      unique case (region_r) inside
        R_FIRST, R_AFTER_TAGS: begin
          if (b == CH_SPACE) begin
            region_nxt = R_ERR;
            lerr_nxt   = (region_r == R_FIRST) ? ST_EMPTY_FIRST : ST_NO_CMD;
          end else if (b == CH_AT && region_r == R_FIRST) begin
            region_nxt = R_KEY;
            start_nxt  = 1'b1;
          end else if (b == CH_COLON) begin
            region_nxt = R_NICK;
            start_nxt  = 1'b1;
          end else begin
            do_cmd = 1'b1;
          end
        end
        R_KEY: begin
          if (b == CH_EQ) begin
            region_nxt = R_VALUE;
            start_nxt  = 1'b1;
          end else if (b == CH_SEMI) begin
            start_nxt = 1'b1;
          end else if (b == CH_SPACE) begin
            region_nxt = R_AFTER_TAGS;
          end else begin
            prim      = mk_beat(K_KEY, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_VALUE: begin
          if (b == CH_SEMI || b == CH_SPACE) begin
            esc_nxt    = 1'b0;
            start_nxt  = 1'b1;
            region_nxt = (b == CH_SEMI) ? R_KEY : R_AFTER_TAGS;
          end else if (esc_r) begin
            esc_nxt   = 1'b0;
            prim      = mk_beat(K_VALUE, unesc(b), start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end else if (b == CH_BSL) begin
            esc_nxt = 1'b1;
          end else begin
            prim      = mk_beat(K_VALUE, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_NICK: begin
          if (b == CH_BANG) begin
            region_nxt = R_USER;
            start_nxt  = 1'b1;
          end else if (b == CH_AT) begin
            region_nxt = R_HOST;
            start_nxt  = 1'b1;
          end else if (b == CH_SPACE) begin
            region_nxt = R_CMD_FIRST;
          end else begin
            prim      = mk_beat(K_NICK, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_USER: begin
          if (b == CH_AT) begin
            region_nxt = R_HOST;
            start_nxt  = 1'b1;
          end else if (b == CH_SPACE) begin
            region_nxt = R_CMD_FIRST;
          end else begin
            prim      = mk_beat(K_USER, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_HOST: begin
          if (b == CH_SPACE) begin
            region_nxt = R_CMD_FIRST;
          end else begin
            prim      = mk_beat(K_HOST, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_CMD_FIRST: begin
          if (b == CH_SPACE) begin
            region_nxt = R_ERR;
            lerr_nxt   = ST_NO_CMD;
          end else begin
            do_cmd = 1'b1;
          end
        end
        R_CMD: begin
          if (b == CH_SPACE) begin
            region_nxt = R_PARAM;
            start_nxt  = 1'b1;
          end else begin
            do_cmd = 1'b1;
          end
        end
        R_PARAM: begin
          if (b == CH_COLON) begin
            region_nxt = R_TRAIL_FIRST;
            start_nxt  = 1'b1;
          end else if (b == CH_SPACE) begin
            if (int'(param_r) < MAX_PARAM_INDEX) param_nxt = param_r + PARAM_W'(1);
            start_nxt = 1'b1;
          end else begin
            prim       = mk_beat(K_MIDDLE, b, 1'b1, pnum);
            prim_vld   = 1'b1;
            start_nxt  = 1'b0;
            region_nxt = R_MIDDLE;
          end
        end
        R_MIDDLE: begin
          if (b == CH_SPACE) begin
            if (int'(param_r) < MAX_PARAM_INDEX) param_nxt = param_r + PARAM_W'(1);
            start_nxt  = 1'b1;
            region_nxt = R_PARAM;
          end else begin
            prim      = mk_beat(K_MIDDLE, b, start_r, pnum);
            prim_vld  = 1'b1;
            start_nxt = 1'b0;
          end
        end
        R_TRAIL_FIRST: begin
          if (b == CH_CTCP && (cmatch_r == M_PRIVMSG || cmatch_r == M_NOTICE)) begin
            ctcp_nxt   = 1'b1;
            start_nxt  = 1'b1;
            region_nxt = R_CTCP_CMD;
          end else begin
            prim       = mk_beat(K_TRAIL, b, start_r, pnum);
            prim_vld   = 1'b1;
            start_nxt  = 1'b0;
            region_nxt = R_TRAIL;
          end
        end
        R_TRAIL: begin
          prim      = mk_beat(K_TRAIL, b, start_r, pnum);
          prim_vld  = 1'b1;
          start_nxt = 1'b0;
        end
        R_CTCP_CMD, R_CTCP_REST: begin
          // release the previous held byte; hold this one for the closing check
          prim_vld = held_vld_r;
          if (region_r == R_CTCP_CMD && b == CH_SPACE) begin
            held_vld_nxt = 1'b0;
            start_nxt    = 1'b1;
            region_nxt   = R_CTCP_REST;
          end else begin
            held_byte_nxt  = b;
            held_kind_nxt  = (region_r == R_CTCP_CMD) ? K_CTCP : K_TRAIL;
            held_vld_nxt   = 1'b1;
            held_start_nxt = start_r;
            start_nxt      = 1'b0;
          end
        end
        default: begin
          // error region: drop bytes until the line ends
        end
      endcase
    end

    if (do_cmd) begin
      cmatch_nxt   = cmd_next(cmatch_r, b);
      prim         = mk_beat(K_COMMAND, b, start_r | ~cmd_seen_r, pnum);
      prim_vld     = 1'b1;
      start_nxt    = 1'b0;
      cmd_seen_nxt = 1'b1;
      region_nxt   = R_CMD;
    end

    if (eol) begin
      stat.field_kind = K_STATUS;
      stat.line_done  = 1'b1;
      if (region_nxt == R_ERR) begin
        stat.line_status = lerr_nxt;
      end else if (ctcp_nxt && !closing) begin
        eol_rel          = mk_beat(held_kind_nxt, held_byte_nxt, held_start_nxt, pnum);
        eol_rel_vld      = held_vld_nxt;
        stat.line_status = ST_BAD_CTCP;
      end else begin
        stat.line_status = cmd_seen_nxt ? ST_OK : ST_NO_CMD;
      end
      // back to start of line
      region_nxt   = R_FIRST;
      esc_nxt      = 1'b0;
      cmatch_nxt   = M_START;
      param_nxt    = '0;
      held_vld_nxt = 1'b0;
      ctcp_nxt     = 1'b0;
      cmd_seen_nxt = 1'b0;
      start_nxt    = 1'b1;
      lerr_nxt     = ST_OK;
    end
  end

  // Compact the results into the push slots, in model order.
  always_comb begin
    n          = 2'd0;
    push.beats = '0;
    if (prim_vld) begin
      push.beats[n] = prim;
      n             = n + 2'd1;
    end
    if (eol_rel_vld) begin
      push.beats[n] = eol_rel;
      n             = n + 2'd1;
    end
    if (eol) begin
      push.beats[n] = stat;
      n             = n + 2'd1;
    end
    push.cnt = fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r     <= R_FIRST;
      esc_r        <= 1'b0;
      cmatch_r     <= M_START;
      param_r      <= '0;
      held_vld_r   <= 1'b0;
      held_start_r <= 1'b0;
      ctcp_r       <= 1'b0;
      cmd_seen_r   <= 1'b0;
      start_r      <= 1'b1;
      lerr_r       <= ST_OK;
    end else if (fire) begin
      region_r     <= region_nxt;
      esc_r        <= esc_nxt;
      cmatch_r     <= cmatch_nxt;
      param_r      <= param_nxt;
      held_vld_r   <= held_vld_nxt;
      held_start_r <= held_start_nxt;
      ctcp_r       <= ctcp_nxt;
      cmd_seen_r   <= cmd_seen_nxt;
      start_r      <= start_nxt;
      lerr_r       <= lerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte_r <= held_byte_nxt;
      held_kind_r <= held_kind_nxt;
    end
  end

endmodule

/* rtl/irc_lfs_fifo.sv */
// Result queue of the IRC line field splitter: takes up to three beats a cycle,
// gives one unless out_stall holds the head. Depends on irc_lfs_pkg.
module irc_lfs_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  irc_lfs_pkg::res_push_t  push,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_stall,
  output irc_lfs_pkg::out_beat_t  out_data
);
  import irc_lfs_pkg::*;

  out_beat_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for a full burst of results from the next byte
  assign room      = (int'(count_r) <= Q_DEPTH - MAX_RESULTS);

  assign wr_ptr_nxt = wr_ptr_r + Q_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
  assign count_nxt  = count_r + Q_CW'(push.cnt) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (k < int'(push.cnt)) mem[wr_ptr_r + Q_AW'(k)] <= push.beats[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/irc_line_field_splitter.sv */
// Top level of the IRC line field splitter: input stage, parser, result queue.
// Depends on irc_lfs_pkg, irc_lfs_parse, irc_lfs_fifo and assert_macros.svh.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall  | in_beat_t: one octet, end-of-line
//   out_    | output    | out_valid/out_stall| out_beat_t: labeled octet or status
//
// One octet per cycle while out_stall is low and each octet yields at most one
// result. An octet that yields two or three results (end of a line, above all one
// inside CTCP framing) holds the next octet in the input stage until the queue,
// which drains one beat a cycle unless out_stall holds it, has room for a full
// burst again. A result passes the input stage, then the queue, before out_.
// Reset clears the stage, the queue and the parse state to start of line.
// in_stall rises only while the stage holds an octet the queue cannot take;
// out_stall holds the queue head in place.
module irc_line_field_splitter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  irc_lfs_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output irc_lfs_pkg::out_beat_t out_data
);
  import irc_lfs_pkg::*;
  `include "assert_macros.svh"

  // Input stage: one registered octet waiting for the parser.
  logic      stg_vld_r, stg_vld_nxt;
  in_beat_t  stg_beat_r;
  logic      in_take;
  logic      fire;
  logic      room;
  res_push_t push;

  // Parse the staged octet whenever the queue can take its worst-case burst.
  assign fire     = stg_vld_r && room;
  // Stall only while a staged octet cannot move on.
  assign in_stall = stg_vld_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_take) begin
      stg_vld_nxt = 1'b1;
    end else if (fire) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Hold the payload unless a new octet is taken.
  always_ff @(posedge clk) begin
    if (in_take) stg_beat_r <= in_data;
  end

  irc_lfs_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (stg_beat_r),
    .push  (push)
  );

  irc_lfs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A staged octet that is not parsed stays put.
  `ASSERT_CLK(a_stage_hold, (stg_vld_r && !fire) |=> (stg_vld_r && $stable(stg_beat_r)), "staged octet lost while queue full")
  // Every parsed end-of-line octet produces at least its status record.
  `ASSERT_CLK(a_eol_status, (fire && stg_beat_r.line_end) |-> (push.cnt != 2'd0), "line end without status record")
  // Nothing is pushed without a parsed octet.
  `ASSERT_NEVER(a_push_idle, (!fire && push.cnt != 2'd0), "results pushed without a parsed octet")
  // A status beat at the output always carries the line-done mark.
  `ASSERT_CLK(a_status_done, (out_valid && out_data.field_kind == K_STATUS) |-> out_data.line_done, "status beat without line done")

endmodule
